FILE: hw/rtl/rrge_pkg.sv
// Shared types and constants of the reversible rectify gate emitter.
package rrge_pkg;

   localparam int WORD_W  = 16;
   localparam int LINE_W  = 4;
   localparam int COUNT_W = 5;
   localparam int LEVEL_W = 32;
   localparam int CSR_W   = 32;
   localparam int ADDR_W  = 3;

   // Register index codes, taken from paddr[2].
   localparam logic REG_GATE_LIBRARY = 1'b0;
   localparam logic REG_LINE_COUNT   = 1'b1;

   // Gate kind codes.
   localparam logic KIND_TOFFOLI = 1'b0;
   localparam logic KIND_FREDKIN = 1'b1;

   localparam logic [COUNT_W-1:0] LINE_COUNT_RESET = 5'd16;

   typedef struct packed {
      logic [WORD_W-1:0] current_value;
      logic [WORD_W-1:0] target_value;
   } rrge_req_type;

   typedef struct packed {
      logic               gate_kind;
      logic [LINE_W-1:0]  target_line;
      logic [LINE_W-1:0]  swap_line;
      logic [WORD_W-1:0]  control_mask;
      logic [LEVEL_W-1:0] gate_level;
      logic               last_gate;
   } rrge_rsp_type;

   // Result of the lowest-set-bit finder.
   typedef struct packed {
      logic [LINE_W-1:0] index;
      logic [WORD_W-1:0] onehot;
   } rrge_lsb_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAIR_UP,
      ST_PAIR_DN,
      ST_PAIR_SWAP,
      ST_RAISE,
      ST_CLEAR
   } rrge_state_type;

endpackage

FILE: hw/rtl/rrge_lsb_find.sv
// Lowest-set-bit finder shared by the search steps of the gate sequencer.
module rrge_lsb_find (
   input  logic [rrge_pkg::WORD_W-1:0] vec,
   output rrge_pkg::rrge_lsb_type      lsb
);
   import rrge_pkg::*;

   logic [LINE_W-1:0] index;

   // Scan downward so the lowest set bit wins.
   always_comb begin
      index = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (vec[i]) begin
            index = LINE_W'(i);
         end
      end
   end

   assign lsb.index  = index;
   assign lsb.onehot = vec & (~vec + WORD_W'(1));

endmodule

FILE: hw/rtl/reversible_rectify_gate_emitter.sv
// Top level of the reversible rectify gate emitter: sequencer, registers and APB port.
//
// Takes a current and a target line word and emits, one word per gate, the
// reversible gates that map current onto target. Only the lowest line_count
// lines (capped at MAX_LINES and at 16) take part. With gate_library set,
// 0-to-1 lines are first paired with 1-to-0 lines in ascending order; each
// pair gives two Fredkin gates controlled by the current one-bits outside the
// pair, and the pair is swapped in the working word. Toffoli gates follow:
// lines to raise first, controlled by the working ones plus lines already
// raised, then lines to clear, controlled by the target ones. Each Toffoli
// gate carries the next value of a 32-bit level counter that wraps. Equal
// words give no gate. Timing: one item is taken per cycle while the block is
// idle; after that the block holds req_stall high until its last gate has
// been loaded into the output register, which rsp_stall can delay by holding
// the output register full. The block has a single lowest-set-bit finder,
// which serves one search a cycle, and one output register, which takes one
// gate a cycle while it is not stalled. Configuration registers: gate_library
// at byte address 0, line_count at byte address 4; write them only while the
// block is idle.
module reversible_rectify_gate_emitter #(
   parameter int MAX_LINES = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  rrge_pkg::rrge_req_type      req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output rrge_pkg::rrge_rsp_type      rsp_data,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [rrge_pkg::ADDR_W-1:0] paddr,
   input  logic [rrge_pkg::CSR_W-1:0]  pwdata,
   output logic [rrge_pkg::CSR_W-1:0]  prdata,
   output logic                        pready
);
   import rrge_pkg::*;

   // Lines actually usable: the parameter cap, and never more than the word.
   localparam int LINE_CAP = (MAX_LINES < WORD_W) ? MAX_LINES : WORD_W;

   // Control state.
   rrge_state_type       state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]   level_ff, level_in;
   logic                 lib_ff;
   logic [COUNT_W-1:0]   lcount_ff;

   // Working payload.
   logic [WORD_W-1:0]    up_ff, up_in;
   logic [WORD_W-1:0]    dn_ff, dn_in;
   logic [WORD_W-1:0]    cur_ff, cur_in;
   logic [WORD_W-1:0]    tgt_ff, tgt_in;
   logic [LINE_W-1:0]    a_ff, a_in;
   logic [LINE_W-1:0]    b_ff, b_in;
   rrge_rsp_type         rsp_data_ff, rsp_data_in;

   // Combinational helpers.
   logic                 req_fire;
   logic                 csr_write;
   logic                 go;
   logic                 emit;
   rrge_rsp_type         gate;
   logic [COUNT_W-1:0]   lines_used;
   logic [WORD_W-1:0]    line_mask;
   logic [WORD_W-1:0]    cur_m, tgt_m, up0, dn0;
   logic [WORD_W-1:0]    enc_vec;
   rrge_lsb_type         enc;
   logic [WORD_W-1:0]    a_bit, b_bit;
   logic [WORD_W-1:0]    dn_pair;
   logic [WORD_W-1:0]    pair_up_rest, pair_dn_rest;
   logic [WORD_W-1:0]    raise_rest, clear_rest;

   // ---------------------------------------------------------------------
   // Handshakes
   // ---------------------------------------------------------------------
   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   // The output register can take a new gate when empty or being drained.
   assign go        = !rsp_valid_ff || !rsp_stall;

   // ---------------------------------------------------------------------
   // Configuration port
   // ---------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      case (paddr[2])
         REG_GATE_LIBRARY: prdata = {{(CSR_W-1){1'b0}}, lib_ff};
         REG_LINE_COUNT:   prdata = {{(CSR_W-COUNT_W){1'b0}}, lcount_ff};
         default:          prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Line mask and first look at a new word
   // ---------------------------------------------------------------------
   assign lines_used = (lcount_ff > COUNT_W'(LINE_CAP)) ? COUNT_W'(LINE_CAP) : lcount_ff;

   always_comb begin
      for (int i = 0; i < WORD_W; i++) begin
         line_mask[i] = (COUNT_W'(i) < lines_used);
      end
   end

   assign cur_m = req_data.current_value & line_mask;
   assign tgt_m = req_data.target_value & line_mask;
   assign up0   = tgt_m & ~cur_m;
   assign dn0   = cur_m & ~tgt_m;

   // ---------------------------------------------------------------------
   // Shared lowest-bit finder: raise set in search-up steps, clear set else
   // ---------------------------------------------------------------------
   always_comb begin
      if (state_ff inside {ST_PAIR_DN, ST_CLEAR}) begin
         enc_vec = dn_ff;
      end else begin
         enc_vec = up_ff;
      end
   end

   rrge_lsb_find u_lsb (
      .vec (enc_vec),
      .lsb (enc)
   );

   assign a_bit        = WORD_W'(1) << a_ff;
   assign b_bit        = WORD_W'(1) << b_ff;
   assign dn_pair      = a_bit | enc.onehot;
   assign pair_up_rest = up_ff & ~a_bit;
   assign pair_dn_rest = dn_ff & ~b_bit;
   assign raise_rest   = up_ff & ~enc.onehot;
   assign clear_rest   = dn_ff & ~enc.onehot;

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (cur_m != tgt_m)) begin
               if (lib_ff && (up0 != '0) && (dn0 != '0)) begin
                  state_in = ST_PAIR_UP;
               end else if (up0 != '0) begin
                  state_in = ST_RAISE;
               end else begin
                  state_in = ST_CLEAR;
               end
            end
         end
         ST_PAIR_UP: begin
            state_in = ST_PAIR_DN;
         end
         ST_PAIR_DN: begin
            if (go) begin
               state_in = ST_PAIR_SWAP;
            end
         end
         ST_PAIR_SWAP: begin
            if (go) begin
               if ((pair_up_rest != '0) && (pair_dn_rest != '0)) begin
                  state_in = ST_PAIR_UP;
               end else if (pair_up_rest != '0) begin
                  state_in = ST_RAISE;
               end else if (pair_dn_rest != '0) begin
                  state_in = ST_CLEAR;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_RAISE: begin
            if (go) begin
               if (raise_rest != '0) begin
                  state_in = ST_RAISE;
               end else if (dn_ff != '0) begin
                  state_in = ST_CLEAR;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_CLEAR: begin
            if (go && (clear_rest == '0)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Datapath and gate build
   // ---------------------------------------------------------------------
   always_comb begin
      emit     = 1'b0;
      gate     = '0;
      up_in    = up_ff;
      dn_in    = dn_ff;
      cur_in   = cur_ff;
      tgt_in   = tgt_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      level_in = level_ff;
      case (state_ff)
         ST_IDLE: begin
            // Load the masked words; unused when they are equal.
            if (req_fire) begin
               up_in  = up0;
               dn_in  = dn0;
               cur_in = cur_m;
               tgt_in = tgt_m;
            end
         end
         ST_PAIR_UP: begin
            // Hold the lowest line to raise for this pair.
            a_in = enc.index;
         end
         ST_PAIR_DN: begin
            b_in              = enc.index;
            gate.gate_kind    = KIND_FREDKIN;
            gate.target_line  = enc.index;
            gate.swap_line    = a_ff;
            gate.control_mask = cur_ff & ~dn_pair;
            emit              = go;
         end
         ST_PAIR_SWAP: begin
            gate.gate_kind    = KIND_FREDKIN;
            gate.target_line  = a_ff;
            gate.swap_line    = b_ff;
            gate.control_mask = cur_ff & ~(a_bit | b_bit);
            gate.last_gate    = (pair_up_rest == '0) && (pair_dn_rest == '0);
            emit              = go;
            if (go) begin
               cur_in = cur_ff ^ (a_bit | b_bit);
               up_in  = pair_up_rest;
               dn_in  = pair_dn_rest;
            end
         end
         ST_RAISE: begin
            gate.gate_kind    = KIND_TOFFOLI;
            gate.target_line  = enc.index;
            gate.control_mask = cur_ff;
            gate.gate_level   = level_ff + LEVEL_W'(1);
            gate.last_gate    = (raise_rest == '0) && (dn_ff == '0);
            emit              = go;
            if (go) begin
               // Raised lines join the controls of later raises.
               cur_in   = cur_ff | enc.onehot;
               up_in    = raise_rest;
               level_in = level_ff + LEVEL_W'(1);
            end
         end
         ST_CLEAR: begin
            gate.gate_kind    = KIND_TOFFOLI;
            gate.target_line  = enc.index;
            gate.control_mask = tgt_ff;
            gate.gate_level   = level_ff + LEVEL_W'(1);
            gate.last_gate    = (clear_rest == '0);
            emit              = go;
            if (go) begin
               dn_in    = clear_rest;
               level_in = level_ff + LEVEL_W'(1);
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // Output register: load a fresh gate, or drop the word once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = gate;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         level_ff     <= '0;
         lib_ff       <= 1'b0;
         lcount_ff    <= LINE_COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         level_ff     <= level_in;
         if (csr_write) begin
            case (paddr[2])
               REG_GATE_LIBRARY: lib_ff    <= pwdata[0];
               REG_LINE_COUNT:   lcount_ff <= pwdata[COUNT_W-1:0];
               default:          lib_ff    <= lib_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      up_ff       <= up_in;
      dn_ff       <= dn_in;
      cur_ff      <= cur_in;
      tgt_ff      <= tgt_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      rsp_data_ff <= rsp_data_in;
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
`ifndef ASSERT_OFF
   a_pair_has_both : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PAIR_UP) |-> ((up_ff != '0) && (dn_ff != '0)))
      else $error("pairing step entered without lines on both sides");

   a_raise_has_work : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_RAISE) |-> (up_ff != '0)) and
      ((state_ff == ST_CLEAR) |-> (dn_ff != '0)))
      else $error("Toffoli step entered with no line left");

   a_last_ends_item : assert property (@(posedge clock) disable iff (reset)
      (emit && gate.last_gate) |=> (state_ff == ST_IDLE))
      else $error("sequencer busy after its last gate");

   a_level_only_toffoli : assert property (@(posedge clock) disable iff (reset)
      !(emit && (gate.gate_kind == KIND_TOFFOLI)) |=> $stable(level_ff))
      else $error("level counter moved without a Toffoli gate");
`endif

endmodule
